>>> rtl/core/modular_range_add_range_sum_tree_core_macros.svh
// Assertion helpers for the range-sum tree core.
// Both sample on clk and are off while arst_n is low.
`ifndef MODULAR_RANGE_ADD_RANGE_SUM_TREE_CORE_MACROS_SVH
`define MODULAR_RANGE_ADD_RANGE_SUM_TREE_CORE_MACROS_SVH

// same-cycle implication
`define MRST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MRST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/mrst_pkg.sv
package mrst_pkg;

	localparam int DATA_W     = 32;
	localparam int LEAF_W     = 11;
	localparam int ADDR_W     = 4;
	localparam int DEF_LEAVES = 1024;

	localparam logic [DATA_W-1:0] DEF_MODULUS = 32'd1000000007;
	localparam logic [DATA_W-1:0] DEF_START   = 32'd1;

	// request codes
	localparam logic [1:0] REQ_BUILD = 2'd0;
	localparam logic [1:0] REQ_ADD   = 2'd1;
	localparam logic [1:0] REQ_SUM   = 2'd2;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_LEAVES  = 2'd0;
	localparam logic [1:0] REG_MODULUS = 2'd1;
	localparam logic [1:0] REG_START   = 2'd2;

	// where a tree walk frame resumes
	typedef enum logic [1:0] {
		PH_ENTER   = 2'd0,
		PH_AFTER_L = 2'd1,
		PH_AFTER_R = 2'd2
	} phase_t;

	typedef enum logic [21:0] {
		ST_IDLE   = 22'd1 << 0,
		ST_CLEAR  = 22'd1 << 1,
		ST_S0     = 22'd1 << 2,
		ST_VMOD   = 22'd1 << 3,
		ST_ROOT   = 22'd1 << 4,
		ST_NODE   = 22'd1 << 5,
		ST_FULL   = 22'd1 << 6,
		ST_FA_SUM = 22'd1 << 7,
		ST_FA_WR  = 22'd1 << 8,
		ST_RET    = 22'd1 << 9,
		ST_PQ     = 22'd1 << 10,
		ST_DESC   = 22'd1 << 11,
		ST_RDL    = 22'd1 << 12,
		ST_RDR    = 22'd1 << 13,
		ST_RDN    = 22'd1 << 14,
		ST_IW     = 22'd1 << 15,
		ST_POP    = 22'd1 << 16,
		ST_OUT    = 22'd1 << 17,
		ST_MUL    = 22'd1 << 18,
		ST_ADD    = 22'd1 << 19,
		ST_CHK    = 22'd1 << 20,
		ST_RED    = 22'd1 << 21
	} state_t;

endpackage

>>> rtl/core/modular_range_add_range_sum_tree_core.sv
// Range-add / range-sum segment tree, all arithmetic modulo a programmable modulus.
// Requests come in on req_* (valid/ready): rebuild, range add over
// [range_low, range_high] (1-based, inclusive), or range sum. A sum request
// gives one transfer on resp_*; rebuild and add give none. Config goes through
// the APB port (leaves_in_use at 0x0, modulus at 0x4, leaf_start_value at 0x8).
// One request at a time: req_ready is high only while idle. Each visited
// tree node takes a node memory access and up to two passes through the
// shared modular unit, which ends in one subtract when the sum is below twice
// the modulus, else in bit-serial remaindering. An add or sum visits about
// 4*log2(n) nodes. A rebuild sweeps all 4*LEAVES node words to zero (one per
// cycle) and then walks the 2n-1 tree nodes.
// After reset the same sweep and walk run with the reset register values
// before req_ready rises.
// A finished sum waits in the output register while the core takes the next
// request; a second sum that finishes while resp_ready is still low holds
// the core until the first transfer, and no new request is taken meanwhile.
`include "modular_range_add_range_sum_tree_core_macros.svh"

module modular_range_add_range_sum_tree_core
	import mrst_pkg::*;
#(
	parameter int LEAVES = DEF_LEAVES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        req_type,
	input  logic [LEAF_W-1:0] range_low,
	input  logic [LEAF_W-1:0] range_high,
	input  logic [DATA_W-1:0] add_value,
	output logic              resp_valid,
	input  logic              resp_ready,
	output logic [DATA_W-1:0] range_sum
);

	localparam int IW    = $clog2(LEAVES + 1);
	localparam int CW    = (IW > LEAF_W) ? IW : LEAF_W;
	localparam int NODES = 4 * LEAVES;
	localparam int NW    = $clog2(NODES);
	localparam int SD    = $clog2(LEAVES) + 1;
	localparam int SIW   = (SD > 1) ? $clog2(SD) : 1;
	localparam int PW    = IW + DATA_W;
	localparam int TW    = IW + DATA_W + 1;
	localparam int KW    = $clog2(TW + 1);
	localparam int RstLeaves = (LEAVES > 2047) ? 2047 : LEAVES;

	// config registers
	logic [LEAF_W-1:0] leaves_q;
	logic [DATA_W-1:0] modulus_q;
	logic [DATA_W-1:0] start_cfg_q;

	// sequencer and latched request
	state_t            state_q, after_q;
	logic [1:0]        op_q;
	logic [LEAF_W-1:0] lo_q, hi_q;
	logic [DATA_W-1:0] v_q;
	logic [DATA_W:0]   m_q;
	logic [IW-1:0]     n_q;
	logic [DATA_W-1:0] start_q, s0_q;
	logic [NW-1:0]     clr_q;

	// current frame and walk stack
	logic [NW-1:0]     cur_nd_q;
	logic [IW-1:0]     cur_b_q, cur_e_q;
	logic [DATA_W-1:0] cur_c_q, cur_f_q;
	phase_t            cur_ph_q;
	logic [SIW-1:0]    sp_q;
	logic [DATA_W-1:0] ret_q;
	logic [NW-1:0]     stk_nd [SD];
	logic [IW-1:0]     stk_b  [SD];
	logic [IW-1:0]     stk_e  [SD];
	logic [DATA_W-1:0] stk_c  [SD];
	logic [DATA_W-1:0] stk_f  [SD];
	phase_t            stk_ph [SD];

	// shared modular unit: (ax + ay + alen*az) mod m
	logic [DATA_W-1:0] ax_q, ay_q, az_q;
	logic [IW-1:0]     alen_q;
	logic [PW-1:0]     prod_q;
	logic [TW-1:0]     t_q;
	logic [DATA_W:0]   r_q;
	logic [KW-1:0]     cnt_q;
	logic [DATA_W-1:0] ares_q, tmp_q, hold_q;

	logic              resp_valid_q;
	logic [DATA_W-1:0] range_sum_q;

	// node memory: {pending, sum}
	logic [2*DATA_W-1:0] mem [NODES];
	logic [2*DATA_W-1:0] rd_q;
	logic                mem_we;
	logic [NW-1:0]       mem_addr;
	logic [2*DATA_W-1:0] mem_wdata;

	logic [CW-1:0]     lo_c, hi_c, b_c, e_c, leaves_c;
	logic              outside, full, leaf, is_build, is_sum, is_add;
	logic [IW:0]       bsum;
	logic [IW-1:0]     mid, len, n_next;
	logic [NW-1:0]     nd_l, nd_r;
	logic [DATA_W-1:0] rd_sum, rd_pend, desc_c;
	logic [DATA_W:0]   m_next;
	logic [DATA_W+1:0] r2, r2_red;
	logic [TW-1:0]     twom, m_t;
	logic              push_en;
	phase_t            push_ph;
	logic [DATA_W-1:0] push_f;
	logic [SIW-1:0]    sp_m1;
	logic              cfg_wr;

	assign pready     = 1'b1;
	assign req_ready  = (state_q == ST_IDLE);
	assign resp_valid = resp_valid_q;
	assign range_sum  = range_sum_q;
	assign cfg_wr     = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_LEAVES:  prdata = {{(DATA_W-LEAF_W){1'b0}}, leaves_q};
			REG_MODULUS: prdata = modulus_q;
			REG_START:   prdata = start_cfg_q;
			default:     prdata = '0;
		endcase
	end

	// request decode
	always_comb begin
		leaves_c = CW'(leaves_q);
		if (leaves_c == '0) begin
			n_next = IW'(1);
		end else if (leaves_c > CW'(LEAVES)) begin
			n_next = IW'(LEAVES);
		end else begin
			n_next = IW'(leaves_c);
		end
		m_next = (modulus_q == '0) ? {1'b1, {DATA_W{1'b0}}} : {1'b0, modulus_q};
	end

	// node geometry
	always_comb begin
		lo_c     = CW'(lo_q);
		hi_c     = CW'(hi_q);
		b_c      = CW'(cur_b_q);
		e_c      = CW'(cur_e_q);
		outside  = (lo_c > e_c) || (hi_c < b_c);
		full     = (b_c >= lo_c) && (e_c <= hi_c);
		leaf     = (cur_b_q == cur_e_q);
		bsum     = {1'b0, cur_b_q} + {1'b0, cur_e_q};
		mid      = bsum[IW:1];
		len      = cur_e_q - cur_b_q + IW'(1);
		nd_l     = {cur_nd_q[NW-2:0], 1'b0};
		nd_r     = {cur_nd_q[NW-2:0], 1'b1};
		is_build = (op_q == REQ_BUILD);
		is_add   = (op_q == REQ_ADD);
		is_sum   = (op_q == REQ_SUM);
		rd_sum   = rd_q[DATA_W-1:0];
		rd_pend  = rd_q[2*DATA_W-1:DATA_W];
		desc_c   = is_sum ? ares_q : cur_c_q;
		sp_m1    = sp_q - SIW'(1);
	end

	// remainder step and range check of the modular unit
	always_comb begin
		r2     = {r_q, t_q[TW-1]};
		r2_red = (r2 >= {1'b0, m_q}) ? (r2 - {1'b0, m_q}) : r2;
		twom   = TW'({m_q, 1'b0});
		m_t    = TW'(m_q);
	end

	always_comb begin
		push_en = (state_q == ST_DESC) || (state_q == ST_NODE && cur_ph_q == PH_AFTER_L);
		push_ph = (state_q == ST_DESC) ? PH_AFTER_L : PH_AFTER_R;
		push_f  = (state_q == ST_DESC) ? cur_f_q : ret_q;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = cur_nd_q;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_addr = clr_q;
				mem_we   = 1'b1;
			end
			ST_NODE: begin
				if (cur_ph_q == PH_AFTER_R) begin
					mem_addr = nd_l;
				end else if (cur_ph_q == PH_ENTER && is_build && leaf) begin
					mem_we    = 1'b1;
					mem_wdata = {{DATA_W{1'b0}}, s0_q};
				end
			end
			ST_FA_WR: begin
				mem_we    = 1'b1;
				mem_wdata = {ares_q, tmp_q};
			end
			ST_RDL: mem_addr = nd_r;
			ST_IW: begin
				mem_we    = 1'b1;
				mem_wdata = {az_q, ares_q};
			end
			default: mem_addr = cur_nd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			stk_nd[sp_q] <= cur_nd_q;
			stk_b[sp_q]  <= cur_b_q;
			stk_e[sp_q]  <= cur_e_q;
			stk_c[sp_q]  <= desc_c;
			stk_f[sp_q]  <= push_f;
			stk_ph[sp_q] <= push_ph;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaves_q    <= LEAF_W'(RstLeaves);
			modulus_q   <= DEF_MODULUS;
			start_cfg_q <= DEF_START;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LEAVES:  leaves_q    <= pwdata[LEAF_W-1:0];
				REG_MODULUS: modulus_q   <= pwdata;
				REG_START:   start_cfg_q <= pwdata;
				default:     leaves_q    <= leaves_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			after_q      <= ST_IDLE;
			op_q         <= REQ_BUILD;
			lo_q         <= '0;
			hi_q         <= '0;
			v_q          <= '0;
			m_q          <= {1'b0, DEF_MODULUS};
			n_q          <= IW'(LEAVES);
			start_q      <= DEF_START;
			s0_q         <= '0;
			clr_q        <= '0;
			cur_nd_q     <= '0;
			cur_b_q      <= '0;
			cur_e_q      <= '0;
			cur_c_q      <= '0;
			cur_f_q      <= '0;
			cur_ph_q     <= PH_ENTER;
			sp_q         <= '0;
			ret_q        <= '0;
			ax_q         <= '0;
			ay_q         <= '0;
			az_q         <= '0;
			alen_q       <= '0;
			prod_q       <= '0;
			t_q          <= '0;
			r_q          <= '0;
			cnt_q        <= '0;
			ares_q       <= '0;
			tmp_q        <= '0;
			hold_q       <= '0;
			resp_valid_q <= 1'b0;
			range_sum_q  <= '0;
		end else begin
			// in ST_OUT the output register is reloaded below instead
			if (resp_valid_q && resp_ready && state_q != ST_OUT) begin
				resp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q    <= req_type;
						lo_q    <= range_low;
						hi_q    <= range_high;
						v_q     <= add_value;
						m_q     <= m_next;
						n_q     <= n_next;
						start_q <= start_cfg_q;
						case (req_type)
							REQ_BUILD: begin
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							REQ_ADD: begin
								ax_q    <= add_value;
								ay_q    <= '0;
								az_q    <= '0;
								alen_q  <= '0;
								after_q <= ST_VMOD;
								state_q <= ST_MUL;
							end
							REQ_SUM: state_q <= ST_ROOT;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(NODES - 1)) begin
						ax_q    <= start_q;
						ay_q    <= '0;
						az_q    <= '0;
						alen_q  <= '0;
						after_q <= ST_S0;
						state_q <= ST_MUL;
					end
				end
				ST_S0: begin
					s0_q    <= ares_q;
					state_q <= ST_ROOT;
				end
				ST_VMOD: begin
					v_q     <= ares_q;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					cur_nd_q <= NW'(1);
					cur_b_q  <= IW'(1);
					cur_e_q  <= n_q;
					cur_c_q  <= '0;
					cur_f_q  <= '0;
					cur_ph_q <= PH_ENTER;
					sp_q     <= '0;
					state_q  <= ST_NODE;
				end
				ST_NODE: begin
					case (cur_ph_q)
						PH_ENTER: begin
							if (is_build) begin
								state_q <= leaf ? ST_POP : ST_DESC;
							end else if (outside) begin
								ret_q   <= '0;
								state_q <= ST_POP;
							end else if (full) begin
								state_q <= ST_FULL;
							end else if (is_sum) begin
								state_q <= ST_PQ;
							end else begin
								state_q <= ST_DESC;
							end
						end
						PH_AFTER_L: begin
							cur_nd_q <= nd_r;
							cur_b_q  <= mid + IW'(1);
							cur_ph_q <= PH_ENTER;
							sp_q     <= sp_q + SIW'(1);
						end
						PH_AFTER_R: begin
							if (is_sum) begin
								ax_q    <= cur_f_q;
								ay_q    <= ret_q;
								az_q    <= '0;
								alen_q  <= '0;
								after_q <= ST_RET;
								state_q <= ST_MUL;
							end else begin
								state_q <= ST_RDL;
							end
						end
						default: state_q <= ST_POP;
					endcase
				end
				ST_FULL: begin
					ax_q   <= rd_sum;
					ay_q   <= '0;
					alen_q <= len;
					hold_q <= rd_pend;
					if (is_sum) begin
						az_q    <= cur_c_q;
						after_q <= ST_RET;
					end else begin
						az_q    <= v_q;
						after_q <= ST_FA_SUM;
					end
					state_q <= ST_MUL;
				end
				ST_FA_SUM: begin
					tmp_q   <= ares_q;
					ax_q    <= hold_q;
					ay_q    <= v_q;
					az_q    <= '0;
					alen_q  <= '0;
					after_q <= ST_FA_WR;
					state_q <= ST_MUL;
				end
				ST_FA_WR: state_q <= ST_POP;
				ST_RET: begin
					ret_q   <= ares_q;
					state_q <= ST_POP;
				end
				ST_PQ: begin
					// carry handed to both children
					ax_q    <= cur_c_q;
					ay_q    <= rd_pend;
					az_q    <= '0;
					alen_q  <= '0;
					after_q <= ST_DESC;
					state_q <= ST_MUL;
				end
				ST_DESC: begin
					cur_nd_q <= nd_l;
					cur_e_q  <= mid;
					cur_c_q  <= desc_c;
					cur_ph_q <= PH_ENTER;
					sp_q     <= sp_q + SIW'(1);
					state_q  <= ST_NODE;
				end
				ST_RDL: begin
					ax_q    <= rd_sum;
					state_q <= ST_RDR;
				end
				ST_RDR: begin
					ay_q    <= rd_sum;
					state_q <= ST_RDN;
				end
				ST_RDN: begin
					// pending add is kept and written back unchanged
					az_q    <= is_add ? rd_pend : '0;
					alen_q  <= len;
					after_q <= ST_IW;
					state_q <= ST_MUL;
				end
				ST_IW: state_q <= ST_POP;
				ST_POP: begin
					if (sp_q == '0) begin
						state_q <= is_sum ? ST_OUT : ST_IDLE;
					end else begin
						cur_nd_q <= stk_nd[sp_m1];
						cur_b_q  <= stk_b[sp_m1];
						cur_e_q  <= stk_e[sp_m1];
						cur_c_q  <= stk_c[sp_m1];
						cur_f_q  <= stk_f[sp_m1];
						cur_ph_q <= stk_ph[sp_m1];
						sp_q     <= sp_m1;
						state_q  <= ST_NODE;
					end
				end
				ST_OUT: begin
					if (!resp_valid_q || resp_ready) begin
						resp_valid_q <= 1'b1;
						range_sum_q  <= ret_q;
						state_q      <= ST_IDLE;
					end
				end
				ST_MUL: begin
					prod_q  <= {{DATA_W{1'b0}}, alen_q} * {{IW{1'b0}}, az_q};
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					t_q     <= TW'(ax_q) + TW'(ay_q) + TW'(prod_q);
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					// below 2m: one subtract; else remainder one bit per cycle
					if (t_q < twom) begin
						ares_q  <= (t_q >= m_t) ? DATA_W'(t_q - m_t) : t_q[DATA_W-1:0];
						state_q <= after_q;
					end else begin
						r_q     <= '0;
						cnt_q   <= KW'(TW);
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					r_q   <= r2_red[DATA_W:0];
					t_q   <= {t_q[TW-2:0], 1'b0};
					cnt_q <= cnt_q - KW'(1);
					if (cnt_q == KW'(1)) begin
						ares_q  <= r2_red[DATA_W-1:0];
						state_q <= after_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MRST_ASSERT_NOW(a_rem_below_mod, state_q == ST_RED, r_q < m_q, "partial remainder not below modulus")
	`MRST_ASSERT_NOW(a_ret_below_mod, state_q == ST_RET, {1'b0, ares_q} < m_q, "node result not reduced")
	`MRST_ASSERT_NOW(a_out_only_sum, state_q == ST_OUT, op_q == REQ_SUM, "result staged for a non-sum request")
	`MRST_ASSERT_NOW(a_walk_ends_root, state_q == ST_POP && sp_q == '0, cur_nd_q == NW'(1), "walk finished away from the root")
	`MRST_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready && (req_type == REQ_BUILD || req_type == REQ_ADD || req_type == REQ_SUM), state_q != ST_IDLE, "request transfer did not start a walk")

endmodule
